@@ sv/s3f_pkg.sv @@
// ----------------------------------------------------------------------------
// S3-FIFO cache replacement package
// Shared constants, payload types and helper functions for the replacement
// core: queue geometry, register indexes, location codes and address math.
// ----------------------------------------------------------------------------
package s3f_pkg;

  // Geometry of the queues and the entry pool.
  localparam int MAX_QUEUE   = 32;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int POOL_SIZE   = 3 * MAX_QUEUE;
  localparam int POOL_W      = $clog2(POOL_SIZE);
  localparam int POS_W       = $clog2(MAX_QUEUE);
  localparam int CNT_W       = $clog2(MAX_QUEUE + 1);
  localparam int ORDER_DEPTH = 3 * MAX_QUEUE;
  localparam int ORDER_AW    = $clog2(ORDER_DEPTH);
  localparam int FREE_W      = $clog2(POOL_SIZE + 1);

  // Configuration registers.
  localparam int CAP_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_CAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_CAP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GHOST_CAP = 2'd2;
  localparam logic [CAP_W-1:0] SMALL_CAP_RST = 6'd3;
  localparam logic [CAP_W-1:0] MAIN_CAP_RST  = 6'd29;
  localparam logic [CAP_W-1:0] GHOST_CAP_RST = 6'd32;

  // Operation codes.
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Location codes reported in found_where.
  localparam logic [1:0] WHERE_MISS  = 2'd0;
  localparam logic [1:0] WHERE_SMALL = 2'd1;
  localparam logic [1:0] WHERE_MAIN  = 2'd2;
  localparam logic [1:0] WHERE_GHOST = 2'd3;

  // Queue numbers inside the order memory.
  localparam logic [1:0] QI_SMALL = 2'd0;
  localparam logic [1:0] QI_MAIN  = 2'd1;
  localparam logic [1:0] QI_GHOST = 2'd2;

  typedef struct packed {
    logic                  operation;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic                  found;
    logic [1:0]            found_where;
    logic [VALUE_BITS-1:0] read_value;
  } rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0] small_cap;
    logic [CNT_W-1:0] main_cap;
    logic [CNT_W-1:0] ghost_cap;
  } caps_t;

  typedef struct packed {
    logic                  accessed;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] data;
  } pool_word_t;

  // A capacity of zero acts as one; anything above the queue size saturates.
  function automatic logic [CNT_W-1:0] eff_cap(logic [CAP_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (int'(c) > MAX_QUEUE) begin
      r = CNT_W'(MAX_QUEUE);
    end else begin
      r = CNT_W'(int'(c));
    end
    return r;
  endfunction

  // Order memory address of logical position pos of queue qi.
  function automatic logic [ORDER_AW-1:0] order_addr(logic [1:0] qi,
                                                     logic [POS_W-1:0] head,
                                                     logic [CNT_W-1:0] pos);
    int s;
    s = int'(head) + int'(pos);
    if (s >= MAX_QUEUE) begin
      s = s - MAX_QUEUE;
    end
    return ORDER_AW'(int'(qi) * MAX_QUEUE + s);
  endfunction

  // Location code of a queue.
  function automatic logic [1:0] where_of(logic [1:0] qi);
    logic [1:0] w;
    case (qi)
      QI_SMALL: w = WHERE_SMALL;
      QI_MAIN:  w = WHERE_MAIN;
      QI_GHOST: w = WHERE_GHOST;
      default:  w = WHERE_MISS;
    endcase
    return w;
  endfunction

endpackage

@@ sv/s3f_ram.sv @@
// ----------------------------------------------------------------------------
// S3-FIFO simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module s3f_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ sv/s3f_ctrl.sv @@
// ----------------------------------------------------------------------------
// S3-FIFO request sequencer
// Owns the entry pool, the queue order memory and the free slot stack, and
// steps one request through lookup, promotion and eviction.
// ----------------------------------------------------------------------------
module s3f_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  s3f_pkg::req_t  req_i,
  input  s3f_pkg::caps_t caps_i,
  input  logic          out_free_i,
  output logic          idle_o,
  output logic          done_o,
  output s3f_pkg::rsp_t  rsp_o
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_SCAN_ORD  = 5'd1;
  localparam logic [4:0] S_SCAN_POOL = 5'd2;
  localparam logic [4:0] S_SCAN_CMP  = 5'd3;
  localparam logic [4:0] S_RM_CHK    = 5'd4;
  localparam logic [4:0] S_RM_WR     = 5'd5;
  localparam logic [4:0] S_MI_CHK    = 5'd6;
  localparam logic [4:0] S_ME_POP    = 5'd7;
  localparam logic [4:0] S_ME_RD     = 5'd8;
  localparam logic [4:0] S_ME_TST    = 5'd9;
  localparam logic [4:0] S_ME_PUSH   = 5'd10;
  localparam logic [4:0] S_MI_PUSH   = 5'd11;
  localparam logic [4:0] S_GI_CHK    = 5'd12;
  localparam logic [4:0] S_GI_FREE   = 5'd13;
  localparam logic [4:0] S_GI_PUSH   = 5'd14;
  localparam logic [4:0] S_SE_POP    = 5'd15;
  localparam logic [4:0] S_SE_RD     = 5'd16;
  localparam logic [4:0] S_SE_TST    = 5'd17;
  localparam logic [4:0] S_ALLOC     = 5'd18;
  localparam logic [4:0] S_ALLOC_RD  = 5'd19;
  localparam logic [4:0] S_NEW       = 5'd20;
  localparam logic [4:0] S_DONE      = 5'd21;

  logic [4:0] state_q, state_d;

  // Queue pointers, one set per queue.
  logic [s3f_pkg::POS_W-1:0] head_q [3];
  logic [s3f_pkg::POS_W-1:0] head_d [3];
  logic [s3f_pkg::CNT_W-1:0] cnt_q  [3];
  logic [s3f_pkg::CNT_W-1:0] cnt_d  [3];

  // Free slot bookkeeping.
  logic [s3f_pkg::FREE_W-1:0] fresh_q, fresh_d;
  logic [s3f_pkg::FREE_W-1:0] fcnt_q, fcnt_d;

  // Request context.
  s3f_pkg::req_t             req_q, req_d;
  s3f_pkg::rsp_t             rsp_q, rsp_d;
  logic [1:0]               sq_q, sq_d;
  logic [s3f_pkg::CNT_W-1:0] sp_q, sp_d;
  logic [s3f_pkg::POOL_W-1:0] e_q, e_d;
  logic [s3f_pkg::POOL_W-1:0] x_q, x_d;
  logic [s3f_pkg::POOL_W-1:0] ins_q, ins_d;
  logic [s3f_pkg::CNT_W-1:0] rm_q, rm_d;
  logic                     mi_ret_q, mi_ret_d;
  logic                     gi_ret_q, gi_ret_d;

  // Memory ports.
  logic                         ord_we;
  logic [s3f_pkg::ORDER_AW-1:0] ord_waddr, ord_raddr;
  logic [s3f_pkg::POOL_W-1:0]   ord_wdata, ord_rdata;
  logic                         pool_we;
  logic [s3f_pkg::POOL_W-1:0]   pool_waddr, pool_raddr;
  s3f_pkg::pool_word_t          pool_wdata, pool_rdata;
  logic                         free_we;
  logic [s3f_pkg::POOL_W-1:0]   free_waddr, free_raddr;
  logic [s3f_pkg::POOL_W-1:0]   free_wdata, free_rdata;
  logic [s3f_pkg::FREE_W-1:0]   fcnt_dec;

  assign fcnt_dec = s3f_pkg::FREE_W'(fcnt_q - 1'b1);

  s3f_ram #(.WIDTH(s3f_pkg::POOL_W), .DEPTH(s3f_pkg::ORDER_DEPTH)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  s3f_ram #(.WIDTH($bits(s3f_pkg::pool_word_t)), .DEPTH(s3f_pkg::POOL_SIZE)) u_pool_ram (
    .clk_i   (clk_i),
    .we_i    (pool_we),
    .waddr_i (pool_waddr),
    .wdata_i (pool_wdata),
    .raddr_i (pool_raddr),
    .rdata_o (pool_rdata)
  );

  s3f_ram #(.WIDTH(s3f_pkg::POOL_W), .DEPTH(s3f_pkg::POOL_SIZE)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (free_we),
    .waddr_i (free_waddr),
    .wdata_i (free_wdata),
    .raddr_i (free_raddr),
    .rdata_o (free_rdata)
  );

  // Head pointer after popping one entry.
  function automatic logic [s3f_pkg::POS_W-1:0] head_inc(logic [s3f_pkg::POS_W-1:0] h);
    logic [s3f_pkg::POS_W-1:0] r;
    if (int'(h) == s3f_pkg::MAX_QUEUE - 1) begin
      r = '0;
    end else begin
      r = s3f_pkg::POS_W'(h + 1'b1);
    end
    return r;
  endfunction

  assign idle_o = (state_q == S_IDLE);
  assign rsp_o  = rsp_q;

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    cnt_d    = cnt_q;
    fresh_d  = fresh_q;
    fcnt_d   = fcnt_q;
    req_d    = req_q;
    rsp_d    = rsp_q;
    sq_d     = sq_q;
    sp_d     = sp_q;
    e_d      = e_q;
    x_d      = x_q;
    ins_d    = ins_q;
    rm_d     = rm_q;
    mi_ret_d = mi_ret_q;
    gi_ret_d = gi_ret_q;
    done_o   = 1'b0;

    ord_we     = 1'b0;
    ord_waddr  = '0;
    ord_wdata  = '0;
    ord_raddr  = '0;
    pool_we    = 1'b0;
    pool_waddr = '0;
    pool_wdata = pool_rdata;
    pool_raddr = '0;
    free_we    = 1'b0;
    free_waddr = fcnt_q[s3f_pkg::POOL_W-1:0];
    free_wdata = ord_rdata;
    free_raddr = fcnt_dec[s3f_pkg::POOL_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          sq_d    = s3f_pkg::QI_MAIN;
          sp_d    = '0;
          state_d = S_SCAN_ORD;
        end
      end

      // Lookup walks main, then small, then ghost.
      S_SCAN_ORD: begin
        if (sp_q >= cnt_q[sq_q]) begin
          sp_d = '0;
          if (sq_q == s3f_pkg::QI_MAIN) begin
            sq_d = s3f_pkg::QI_SMALL;
          end else if (sq_q == s3f_pkg::QI_SMALL) begin
            sq_d = s3f_pkg::QI_GHOST;
          end else begin
            rsp_d = '0;
            if (req_q.operation == s3f_pkg::OP_GET) begin
              state_d = S_DONE;
            end else if (cnt_q[s3f_pkg::QI_SMALL] >= caps_i.small_cap) begin
              state_d = S_SE_POP;
            end else begin
              state_d = S_ALLOC;
            end
          end
        end else begin
          ord_raddr = s3f_pkg::order_addr(sq_q, head_q[sq_q], sp_q);
          state_d   = S_SCAN_POOL;
        end
      end

      S_SCAN_POOL: begin
        e_d        = ord_rdata;
        pool_raddr = ord_rdata;
        state_d    = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (pool_rdata.key == req_q.key) begin
          pool_we             = 1'b1;
          pool_waddr          = e_q;
          pool_wdata.accessed = 1'b1;
          rsp_d.found         = 1'b1;
          rsp_d.found_where   = s3f_pkg::where_of(sq_q);
          if (req_q.operation == s3f_pkg::OP_PUT) begin
            pool_wdata.data  = req_q.value;
            rsp_d.read_value = '0;
          end else begin
            rsp_d.read_value = pool_rdata.data;
          end
          if (sq_q == s3f_pkg::QI_GHOST) begin
            rm_d     = sp_q;
            ins_d    = e_q;
            mi_ret_d = 1'b0;
            state_d  = S_RM_CHK;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          sp_d    = s3f_pkg::CNT_W'(sp_q + 1'b1);
          state_d = S_SCAN_ORD;
        end
      end

      // Close the gap a ghost hit leaves, moving each later ghost entry down one place.
      S_RM_CHK: begin
        if (s3f_pkg::CNT_W'(rm_q + 1'b1) < cnt_q[s3f_pkg::QI_GHOST]) begin
          ord_raddr = s3f_pkg::order_addr(s3f_pkg::QI_GHOST, head_q[s3f_pkg::QI_GHOST],
                                          s3f_pkg::CNT_W'(rm_q + 1'b1));
          state_d   = S_RM_WR;
        end else begin
          cnt_d[s3f_pkg::QI_GHOST] = s3f_pkg::CNT_W'(cnt_q[s3f_pkg::QI_GHOST] - 1'b1);
          state_d                  = S_MI_CHK;
        end
      end

      S_RM_WR: begin
        ord_we    = 1'b1;
        ord_waddr = s3f_pkg::order_addr(s3f_pkg::QI_GHOST, head_q[s3f_pkg::QI_GHOST], rm_q);
        ord_wdata = ord_rdata;
        rm_d      = s3f_pkg::CNT_W'(rm_q + 1'b1);
        state_d   = S_RM_CHK;
      end

      // Insert into main; a full main evicts by second chance first.
      S_MI_CHK: begin
        if (cnt_q[s3f_pkg::QI_MAIN] >= caps_i.main_cap) begin
          state_d = S_ME_POP;
        end else begin
          state_d = S_MI_PUSH;
        end
      end

      S_ME_POP: begin
        ord_raddr = s3f_pkg::order_addr(s3f_pkg::QI_MAIN, head_q[s3f_pkg::QI_MAIN], '0);
        head_d[s3f_pkg::QI_MAIN] = head_inc(head_q[s3f_pkg::QI_MAIN]);
        cnt_d[s3f_pkg::QI_MAIN]  = s3f_pkg::CNT_W'(cnt_q[s3f_pkg::QI_MAIN] - 1'b1);
        state_d = S_ME_RD;
      end

      S_ME_RD: begin
        x_d        = ord_rdata;
        pool_raddr = ord_rdata;
        state_d    = S_ME_TST;
      end

      S_ME_TST: begin
        if (!pool_rdata.accessed) begin
          gi_ret_d = 1'b0;
          state_d  = S_GI_CHK;
        end else begin
          pool_we             = 1'b1;
          pool_waddr          = x_q;
          pool_wdata.accessed = 1'b0;
          state_d             = S_ME_PUSH;
        end
      end

      S_ME_PUSH: begin
        if (cnt_q[s3f_pkg::QI_MAIN] < s3f_pkg::CNT_W'(s3f_pkg::MAX_QUEUE)) begin
          ord_we    = 1'b1;
          ord_waddr = s3f_pkg::order_addr(s3f_pkg::QI_MAIN, head_q[s3f_pkg::QI_MAIN],
                                          cnt_q[s3f_pkg::QI_MAIN]);
          ord_wdata = x_q;
          cnt_d[s3f_pkg::QI_MAIN] = s3f_pkg::CNT_W'(cnt_q[s3f_pkg::QI_MAIN] + 1'b1);
        end
        state_d = S_ME_POP;
      end

      S_MI_PUSH: begin
        if (cnt_q[s3f_pkg::QI_MAIN] < s3f_pkg::CNT_W'(s3f_pkg::MAX_QUEUE)) begin
          ord_we    = 1'b1;
          ord_waddr = s3f_pkg::order_addr(s3f_pkg::QI_MAIN, head_q[s3f_pkg::QI_MAIN],
                                          cnt_q[s3f_pkg::QI_MAIN]);
          ord_wdata = ins_q;
          cnt_d[s3f_pkg::QI_MAIN] = s3f_pkg::CNT_W'(cnt_q[s3f_pkg::QI_MAIN] + 1'b1);
        end
        state_d = mi_ret_q ? S_SE_POP : S_DONE;
      end

      // Insert the victim into ghost; a full ghost drops its oldest entry.
      S_GI_CHK: begin
        if (cnt_q[s3f_pkg::QI_GHOST] >= caps_i.ghost_cap &&
            cnt_q[s3f_pkg::QI_GHOST] != '0) begin
          ord_raddr = s3f_pkg::order_addr(s3f_pkg::QI_GHOST, head_q[s3f_pkg::QI_GHOST], '0);
          head_d[s3f_pkg::QI_GHOST] = head_inc(head_q[s3f_pkg::QI_GHOST]);
          cnt_d[s3f_pkg::QI_GHOST]  = s3f_pkg::CNT_W'(cnt_q[s3f_pkg::QI_GHOST] - 1'b1);
          state_d = S_GI_FREE;
        end else begin
          state_d = S_GI_PUSH;
        end
      end

      S_GI_FREE: begin
        free_we = 1'b1;
        fcnt_d  = s3f_pkg::FREE_W'(fcnt_q + 1'b1);
        state_d = S_GI_PUSH;
      end

      S_GI_PUSH: begin
        if (cnt_q[s3f_pkg::QI_GHOST] < s3f_pkg::CNT_W'(s3f_pkg::MAX_QUEUE)) begin
          ord_we    = 1'b1;
          ord_waddr = s3f_pkg::order_addr(s3f_pkg::QI_GHOST, head_q[s3f_pkg::QI_GHOST],
                                          cnt_q[s3f_pkg::QI_GHOST]);
          ord_wdata = x_q;
          cnt_d[s3f_pkg::QI_GHOST] = s3f_pkg::CNT_W'(cnt_q[s3f_pkg::QI_GHOST] + 1'b1);
        end
        state_d = gi_ret_q ? S_ALLOC : S_MI_PUSH;
      end

      // Drain small until a cold entry turns up or small is empty; hot ones go to main.
      S_SE_POP: begin
        if (cnt_q[s3f_pkg::QI_SMALL] == '0) begin
          state_d = S_ALLOC;
        end else begin
          ord_raddr = s3f_pkg::order_addr(s3f_pkg::QI_SMALL, head_q[s3f_pkg::QI_SMALL], '0);
          head_d[s3f_pkg::QI_SMALL] = head_inc(head_q[s3f_pkg::QI_SMALL]);
          cnt_d[s3f_pkg::QI_SMALL]  = s3f_pkg::CNT_W'(cnt_q[s3f_pkg::QI_SMALL] - 1'b1);
          state_d = S_SE_RD;
        end
      end

      S_SE_RD: begin
        x_d        = ord_rdata;
        pool_raddr = ord_rdata;
        state_d    = S_SE_TST;
      end

      S_SE_TST: begin
        if (!pool_rdata.accessed) begin
          gi_ret_d = 1'b1;
          state_d  = S_GI_CHK;
        end else begin
          pool_we             = 1'b1;
          pool_waddr          = x_q;
          pool_wdata.accessed = 1'b0;
          ins_d               = x_q;
          mi_ret_d            = 1'b1;
          state_d             = S_MI_CHK;
        end
      end

      // Take a recycled slot if there is one, else a never-used one.
      S_ALLOC: begin
        if (fcnt_q != '0) begin
          fcnt_d  = fcnt_dec;
          state_d = S_ALLOC_RD;
        end else begin
          ins_d   = fresh_q[s3f_pkg::POOL_W-1:0];
          fresh_d = s3f_pkg::FREE_W'(fresh_q + 1'b1);
          state_d = S_NEW;
        end
      end

      S_ALLOC_RD: begin
        ins_d   = free_rdata;
        state_d = S_NEW;
      end

      S_NEW: begin
        pool_we             = 1'b1;
        pool_waddr          = ins_q;
        pool_wdata.accessed = 1'b0;
        pool_wdata.key      = req_q.key;
        pool_wdata.data     = req_q.value;
        if (cnt_q[s3f_pkg::QI_SMALL] < s3f_pkg::CNT_W'(s3f_pkg::MAX_QUEUE)) begin
          ord_we    = 1'b1;
          ord_waddr = s3f_pkg::order_addr(s3f_pkg::QI_SMALL, head_q[s3f_pkg::QI_SMALL],
                                          cnt_q[s3f_pkg::QI_SMALL]);
          ord_wdata = ins_q;
          cnt_d[s3f_pkg::QI_SMALL] = s3f_pkg::CNT_W'(cnt_q[s3f_pkg::QI_SMALL] + 1'b1);
        end
        state_d = S_DONE;
      end

      // Hand the result over once the output register has room.
      S_DONE: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < 3; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      fresh_q  <= '0;
      fcnt_q   <= '0;
      mi_ret_q <= 1'b0;
      gi_ret_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      cnt_q    <= cnt_d;
      fresh_q  <= fresh_d;
      fcnt_q   <= fcnt_d;
      mi_ret_q <= mi_ret_d;
      gi_ret_q <= gi_ret_d;
    end
  end

  // Request context and scan pointers.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
    sq_q  <= sq_d;
    sp_q  <= sp_d;
    e_q   <= e_d;
    x_q   <= x_d;
    ins_q <= ins_d;
    rm_q  <= rm_d;
  end

endmodule

@@ sv/s3fifo_cache_replacement_core.sv @@
// ----------------------------------------------------------------------------
// S3-FIFO cache replacement core
// Get and put requests against small, main and ghost FIFO queues with
// second-chance eviction from main and promotion out of small.
//
//   Channel | Signals                                  | Direction
//   req     | req_valid_i, req_ready_o, req_i          | in
//   rsp     | rsp_valid_o, rsp_ready_i, rsp_o          | out
//   cfg     | cfg_we_i, cfg_idx_i, cfg_data_i          | in
//
// One request at a time: lookup examines up to 96 entries, each by an order read, a pool
// read and a key compare. A ghost hit then moves each later ghost entry down one place.
// Each popped entry is read and tested: a hot main entry is re-queued, a hot small entry
// enters main and a cold one enters ghost. A new entry is allocated and written before the
// result is handed over. Reset clears the state, pointers, free counts and response valid and
// loads default capacities, not memories. The sequencer holds only while the output is full.
// ----------------------------------------------------------------------------
module s3fifo_cache_replacement_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  output logic                             req_ready_o,
  input  s3f_pkg::req_t                    req_i,
  output logic                             rsp_valid_o,
  input  logic                             rsp_ready_i,
  output s3f_pkg::rsp_t                    rsp_o,
  input  logic                             cfg_we_i,
  input  logic [s3f_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [s3f_pkg::CAP_W-1:0]        cfg_data_i
);

  logic [s3f_pkg::CAP_W-1:0] small_cap_q, main_cap_q, ghost_cap_q;
  s3f_pkg::caps_t caps;
  logic           start, idle, done, out_free;
  s3f_pkg::rsp_t  ctrl_rsp;
  logic           rsp_valid_q, rsp_valid_d;
  s3f_pkg::rsp_t  rsp_q;

  // Capacity registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_cap_q <= s3f_pkg::SMALL_CAP_RST;
      main_cap_q  <= s3f_pkg::MAIN_CAP_RST;
      ghost_cap_q <= s3f_pkg::GHOST_CAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        s3f_pkg::CFG_SMALL_CAP: small_cap_q <= cfg_data_i;
        s3f_pkg::CFG_MAIN_CAP:  main_cap_q  <= cfg_data_i;
        s3f_pkg::CFG_GHOST_CAP: ghost_cap_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign caps.small_cap = s3f_pkg::eff_cap(small_cap_q);
  assign caps.main_cap  = s3f_pkg::eff_cap(main_cap_q);
  assign caps.ghost_cap = s3f_pkg::eff_cap(ghost_cap_q);

  assign req_ready_o = idle;
  assign start       = req_valid_i & idle;
  assign out_free    = !rsp_valid_q || rsp_ready_i;

  s3f_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_i      (req_i),
    .caps_i     (caps),
    .out_free_i (out_free),
    .idle_o     (idle),
    .done_o     (done),
    .rsp_o      (ctrl_rsp)
  );

  // Output register.
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (done) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      rsp_q <= ctrl_rsp;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

@@ sv/s3f_checker.sv @@
// ----------------------------------------------------------------------------
// S3-FIFO port checker
// Watches the core's ports for response consistency and request ordering.
// ----------------------------------------------------------------------------
module s3f_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_o,
  input logic                          rsp_valid_o,
  input logic                          rsp_ready_i,
  input s3f_pkg::rsp_t                 rsp_o
);

  // A stalled response holds.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response changed while stalled");

  // The found flag agrees with the location code.
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> rsp_o.found == (rsp_o.found_where != s3f_pkg::WHERE_MISS))
    else $error("found flag disagrees with location");

  // A miss never carries data.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.found_where == s3f_pkg::WHERE_MISS |-> rsp_o.read_value == '0)
    else $error("miss returned data");

  // After taking a request the core is busy with it.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o)
    else $error("request taken while another is in flight");

endmodule

bind s3fifo_cache_replacement_core s3f_checker u_s3f_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_ready_o (req_ready_o),
  .rsp_valid_o (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_o       (rsp_o)
);
